[design/shc_pkg.sv]
`default_nettype none
package shc_pkg;

  typedef enum logic [1:0] {
    PH_SEEK_BACK = 2'd0,
    PH_MEASURE   = 2'd1,
    PH_POSITION  = 2'd2
  } phase_t;

  localparam logic [1:0] CFG_CENTER_RATIO = 2'd0;
  localparam logic [1:0] CFG_CLOSED_LOOP  = 2'd1;
  localparam logic [1:0] CFG_DEADBAND     = 2'd2;
  localparam logic [1:0] CFG_HOLD_COUNT   = 2'd3;

  localparam logic [9:0] RATIO_RESET    = 10'd512;
  localparam logic [9:0] DEADBAND_RESET = 10'd20;
  localparam logic [7:0] HOLD_RESET     = 8'd20;
  localparam logic [9:0] RATIO_MIN      = 10'd82;
  localparam logic [9:0] RATIO_MAX      = 10'd942;
  localparam logic [5:0] ERR_CLAMP      = 6'd50;
  localparam logic [2:0] MS_RESET       = 3'd1;

  typedef struct packed {
    logic [9:0] center_ratio_q10;
    logic       closed_loop_enable;
    logic [9:0] position_deadband;
    logic [7:0] limit_hold_count;
  } shc_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] base_count;
    logic [15:0] travel_length;
    logic [7:0]  back_hold;
    logic [7:0]  front_hold;
    logic        dir;
    logic        drive;
    logic [2:0]  ms;
  } shc_state_t;

  typedef struct packed {
    logic               back_switch_level;
    logic               front_switch_level;
    logic [15:0]        step_counter_value;
    logic signed [15:0] target_angle;
    logic signed [15:0] measured_angle;
  } shc_item_t;

  typedef struct packed {
    logic       drive_on;
    logic       direction;
    logic [2:0] microstep_select;
    logic       pause_request;
    logic [1:0] phase;
  } shc_result_t;

  typedef struct packed {
    logic       change;
    logic       dir;
    logic [2:0] ms;
  } shc_cl_t;

  function automatic logic [2:0] ms_lookup(input logic [3:0] code);
    logic [2:0] ms;
    case (code)
      4'd0: ms = 3'd5;
      4'd1: ms = 3'd3;
      4'd2, 4'd3, 4'd4: ms = 3'd2;
      4'd5: ms = 3'd1;
      default: ms = 3'd0;
    endcase
    return ms;
  endfunction

endpackage
`default_nettype wire

[design/shc_closed_loop.sv]
`default_nettype none
module shc_closed_loop (
  input  wire logic signed [15:0] target_angle,
  input  wire logic signed [15:0] measured_angle,
  output shc_pkg::shc_cl_t        cl
);
  import shc_pkg::*;

  logic signed [16:0] diff;
  logic        [16:0] ndiff;
  logic               neg;
  logic        [5:0]  mag;
  logic        [13:0] scaled;
  logic        [3:0]  code;

  assign diff  = 17'(target_angle) - 17'(measured_angle);
  assign ndiff = -diff;
  assign neg   = diff[16];

  always_comb begin
    if (neg) begin
      mag = (diff < -17'sd50) ? ERR_CLAMP : ndiff[5:0];
    end else begin
      mag = (diff > 17'sd50) ? ERR_CLAMP : diff[5:0];
    end
  end

  // floor(4*mag/25) as mag*164 >> 10, exact for mag up to 50
  assign scaled = 14'(mag) * 14'd164;
  assign code   = scaled[13:10];

  assign cl.change = (code != 4'd0);
  assign cl.dir    = neg;
  assign cl.ms     = ms_lookup(code);
endmodule
`default_nettype wire

[design/shc_step.sv]
`default_nettype none
module shc_step (
  input  wire shc_pkg::shc_state_t  st,
  input  wire shc_pkg::shc_cfg_t    cfg,
  input  wire shc_pkg::shc_item_t   item,
  output shc_pkg::shc_state_t       st_next,
  output shc_pkg::shc_result_t      result
);
  import shc_pkg::*;

  shc_cl_t            cl;
  logic               back_free;
  logic               front_free;
  logic        [15:0] pos_raw;
  logic        [9:0]  ratio;
  logic signed [26:0] prod;
  logic signed [26:0] prod_adj;
  logic signed [16:0] setpoint;
  logic signed [17:0] err;
  logic signed [17:0] band;
  logic        [7:0]  back_inc;
  logic        [7:0]  front_inc;
  logic               pause;

  shc_closed_loop u_cl (
    .target_angle  (item.target_angle),
    .measured_angle(item.measured_angle),
    .cl            (cl)
  );

  assign back_free  = item.back_switch_level;
  assign front_free = item.front_switch_level;
  assign pos_raw    = item.step_counter_value - st.base_count;

  always_comb begin
    if (cfg.center_ratio_q10 > RATIO_MAX) begin
      ratio = RATIO_MAX;
    end else if (cfg.center_ratio_q10 < RATIO_MIN) begin
      ratio = RATIO_MIN;
    end else begin
      ratio = cfg.center_ratio_q10;
    end
  end

  // truncate toward zero
  assign prod     = $signed(st.travel_length) * $signed({1'b0, ratio});
  assign prod_adj = prod + (prod[26] ? 27'sd1023 : 27'sd0);
  assign setpoint = prod_adj[26:10];
  assign err      = 18'($signed(pos_raw)) - 18'(setpoint);
  assign band     = $signed({8'd0, cfg.position_deadband});
  assign back_inc  = st.back_hold + 8'd1;
  assign front_inc = st.front_hold + 8'd1;

  always_comb begin
    st_next = st;
    pause   = 1'b0;
    if (back_free && front_free && st.phase == PH_SEEK_BACK) begin
      st_next.dir   = 1'b0;
      st_next.drive = 1'b1;
    end else if (!back_free && front_free && st.phase == PH_SEEK_BACK) begin
      st_next.phase      = PH_MEASURE;
      st_next.base_count = item.step_counter_value;
      st_next.dir        = 1'b1;
      st_next.drive      = 1'b1;
    end else if (back_free && !front_free && st.phase == PH_MEASURE) begin
      st_next.phase         = PH_POSITION;
      st_next.travel_length = pos_raw;
      st_next.dir           = 1'b0;
      st_next.drive         = 1'b1;
    end else if (back_free && front_free && st.phase == PH_POSITION) begin
      if (!cfg.closed_loop_enable) begin
        if (err > band) begin
          st_next.dir   = 1'b0;
          st_next.drive = 1'b1;
        end else if (err < -band) begin
          st_next.dir   = 1'b1;
          st_next.drive = 1'b1;
        end else begin
          st_next.drive = 1'b0;
          st_next.phase = PH_SEEK_BACK;
        end
      end else begin
        st_next.drive = 1'b1;
        st_next.ms    = cl.ms;
        if (cl.change) begin
          st_next.dir = cl.dir;
        end
      end
    end

    if (!back_free) begin
      st_next.back_hold = back_inc;
      if (back_inc >= cfg.limit_hold_count) begin
        st_next.dir       = 1'b1;
        st_next.back_hold = 8'd0;
        pause             = 1'b1;
      end
    end
    // front last so it wins the direction
    if (!front_free) begin
      st_next.front_hold = front_inc;
      if (front_inc >= cfg.limit_hold_count) begin
        st_next.dir        = 1'b0;
        st_next.front_hold = 8'd0;
        pause              = 1'b1;
      end
    end
  end

  assign result.drive_on         = st_next.drive;
  assign result.direction        = st_next.dir;
  assign result.microstep_select = st_next.ms;
  assign result.pause_request    = pause;
  assign result.phase            = st_next.phase;
endmodule
`default_nettype wire

[design/stepper_homing_centering_control_unit.sv]
// channel   direction  handshake              payload
// in        request in in_valid / in_ready    switch levels, step counter, angles
// out       result out out_valid / out_ready  drive, direction, microstep, pause, phase
// cfg       write in   cfg_write              cfg_index, cfg_data
//
// an accepted request sits in the input register, then its result is
// loaded into the output register; one request per cycle sustained while out_ready stays high
// the limiting path is the travel times ratio multiply and error compare
// reset clears phase, counters and drive and loads the config registers with their defaults
// a stalled output holds; the input register still takes one more request
`default_nettype none
module stepper_homing_centering_control_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               back_switch_level,
  input  wire logic               front_switch_level,
  input  wire logic [15:0]        step_counter_value,
  input  wire logic signed [15:0] target_angle,
  input  wire logic signed [15:0] measured_angle,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               drive_on,
  output      logic               direction,
  output      logic [2:0]         microstep_select,
  output      logic               pause_request,
  output      logic [1:0]         phase,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [9:0]         cfg_data
);
  import shc_pkg::*;

  shc_cfg_t    cfg;
  shc_state_t  st;
  shc_state_t  st_next;
  shc_item_t   item;
  shc_result_t result;
  shc_result_t res;
  logic        in_full;
  logic        adv;

  assign adv      = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || adv;

  shc_step u_step (
    .st     (st),
    .cfg    (cfg),
    .item   (item),
    .st_next(st_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full                 <= 1'b0;
      out_valid               <= 1'b0;
      st.phase                <= PH_SEEK_BACK;
      st.base_count           <= 16'd0;
      st.travel_length        <= 16'd0;
      st.back_hold            <= 8'd0;
      st.front_hold           <= 8'd0;
      st.dir                  <= 1'b1;
      st.drive                <= 1'b0;
      st.ms                   <= MS_RESET;
      cfg.center_ratio_q10    <= RATIO_RESET;
      cfg.closed_loop_enable  <= 1'b0;
      cfg.position_deadband   <= DEADBAND_RESET;
      cfg.limit_hold_count    <= HOLD_RESET;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_CENTER_RATIO: cfg.center_ratio_q10   <= cfg_data;
          CFG_CLOSED_LOOP:  cfg.closed_loop_enable <= cfg_data[0];
          CFG_DEADBAND:     cfg.position_deadband  <= cfg_data;
          CFG_HOLD_COUNT:   cfg.limit_hold_count   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.back_switch_level  <= back_switch_level;
      item.front_switch_level <= front_switch_level;
      item.step_counter_value <= step_counter_value;
      item.target_angle       <= target_angle;
      item.measured_angle     <= measured_angle;
    end
    if (adv) begin
      res <= result;
    end
  end

  assign drive_on         = res.drive_on;
  assign direction        = res.direction;
  assign microstep_select = res.microstep_select;
  assign pause_request    = res.pause_request;
  assign phase            = res.phase;

`ifndef NO_ASSERTIONS
  a_pause_needs_switch: assert property (@(posedge clk) disable iff (rst)
    (adv && item.back_switch_level && item.front_switch_level) |=> !pause_request)
    else $error("pause raised with both switches released");

  a_stopped_only_seeking: assert property (@(posedge clk) disable iff (rst)
    !st.drive |-> (st.phase == PH_SEEK_BACK))
    else $error("drive stopped outside seek phase");

  a_travel_on_measure_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(st.travel_length)) |->
      $past(adv && st.phase == PH_MEASURE))
    else $error("travel length changed outside end of measure");
`endif
endmodule
`default_nettype wire
